// ----- rtl/sgdmf_pkg.sv -----
// ----------------------------------------------------------------------------
// sgdmf_pkg: shared types and constants for the SGD factorization engine
// Field widths, function codes, register indexes, reset values, FSM states.
// ----------------------------------------------------------------------------
package sgdmf_pkg;

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int ROW_W    = 10;
    localparam int FEAT_W   = 3;
    localparam int FACTOR_W = 24;
    localparam int RATING_W = 8;
    localparam int WORD_W   = 32;
    localparam int SQ_W     = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 144;
    localparam int MUL_W    = 33;

    // Default sizes
    localparam int DEF_NUM_USERS = 1024;
    localparam int DEF_NUM_ITEMS = 1024;
    localparam int DEF_FEATURES  = 8;

    // Register reset values
    localparam logic [23:0] LEARN_RATE_RST = 24'd3355;
    localparam logic [15:0] REG_WEIGHT_RST = 16'd6554;
    localparam logic [23:0] FREEZE_VAL_RST = 24'd39322;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_EN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_VAL = 2'd3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_USER = 3'd0,
        FUNC_WR_ITEM = 3'd1,
        FUNC_TRAIN   = 3'd2,
        FUNC_EVAL    = 3'd3,
        FUNC_RD_USER = 3'd4,
        FUNC_RD_ITEM = 3'd5
    } func_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BASE,
        S_WR,
        S_RD,
        S_RD_DATA,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_ACC,
        S_PRED,
        S_ERR,
        S_SQ_MUL,
        S_SQ,
        S_T_RD,
        S_T_LD,
        S_ST_EO,
        S_ST_RW,
        S_ST_IN,
        S_ST_LO,
        S_ST_HI,
        S_ST_SUM,
        S_ST_NEW,
        S_T_WR,
        S_DONE
    } state_t;

endpackage

// ----- rtl/sgdmf_ram.sv -----
// ----------------------------------------------------------------------------
// sgdmf_ram: factor table
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sgdmf_ram
    import sgdmf_pkg::*;
#(
    parameter int DEPTH = DEF_NUM_USERS * DEF_FEATURES,
    parameter int AW    = 13,
    parameter int DW    = FACTOR_W
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sgdmf_mul.sv -----
// ----------------------------------------------------------------------------
// sgdmf_mul: shared signed multiplier
// 33 x 33 signed product, registered.
// ----------------------------------------------------------------------------
module sgdmf_mul
    import sgdmf_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_W-1:0]   a,
    input  logic signed [MUL_W-1:0]   b,
    output logic signed [2*MUL_W-1:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

// ----- rtl/sgdmf_rem.sv -----
// ----------------------------------------------------------------------------
// sgdmf_rem: index wrap
// Remainder of value modulo MOD by reciprocal multiplication, registered.
// ----------------------------------------------------------------------------
module sgdmf_rem
    import sgdmf_pkg::*;
#(
    parameter int IN_W = ROW_W,
    parameter int MOD  = DEF_NUM_USERS
)
(
    input  logic            clk,
    input  logic            start,
    input  logic [IN_W-1:0] value,
    output logic [IN_W-1:0] rem
);

    localparam int     SH    = 2 * IN_W;
    localparam longint RECIP = (longint'(1) << SH) / MOD;

    logic [63:0]     prod;
    logic [63:0]     q_est;
    logic [63:0]     r_est;
    logic [63:0]     r_fix;
    logic [IN_W-1:0] rem_reg;

    // the quotient estimate is low by at most one; one subtract fixes it
    always_comb
    begin
        prod  = 64'(value) * 64'(RECIP);
        q_est = prod >> SH;
        r_est = 64'(value) - q_est * 64'(MOD);
        r_fix = (r_est >= 64'(MOD)) ? r_est - 64'(MOD) : r_est;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= IN_W'(r_fix);
        end
    end

    assign rem = rem_reg;

endmodule

// ----- rtl/sgd_matrix_factorization_update_top.sv -----
// With a zero rating, evaluate and train stop after the prediction; train skips
//   the update steps and the write-back for a frozen feature.
// Throughput: one transaction at a time, with a return to idle before the next
//   accept; the shared 33x33 multiplier and the single read port of each
//   factor table set the per-feature cost. A stalled result holds the next item's result.
// Reset: rst_n clears sequencer, handshake and configuration registers; tables hold garbage.
// ----------------------------------------------------------------------------
// sgd_matrix_factorization_update_top: SGD matrix factorization engine
// Holds user and item factor tables and trains, evaluates, loads or reads them.
// ----------------------------------------------------------------------------
module sgd_matrix_factorization_update_top
    import sgdmf_pkg::*;
#(
    parameter int NUM_USERS = DEF_NUM_USERS,
    parameter int NUM_ITEMS = DEF_NUM_ITEMS,
    parameter int FEATURES  = DEF_FEATURES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // user[9:0], item[19:10], feature[22:20], factor_in[46:23], rating[54:47]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // func[2:0]
    input  logic [FUNC_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // prediction[31:0], pred_error[63:32], sq_error[111:64],
    // factor_out[135:112], updated[136]
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int UDEPTH = NUM_USERS * FEATURES;
    localparam int IDEPTH = NUM_ITEMS * FEATURES;
    localparam int UA_W   = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
    localparam int IA_W   = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
    localparam int K_W    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    // worst-case dot product: FEATURES products of 2^46
    localparam int ACC_W  = 49 + $clog2(FEATURES);

    // ---------------- configuration registers ----------------
    logic [23:0]          learn_rate_reg;
    logic [15:0]          reg_weight_reg;
    logic                 freeze_en_reg;
    logic [FACTOR_W-1:0]  freeze_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= LEARN_RATE_RST;
            reg_weight_reg <= REG_WEIGHT_RST;
            freeze_en_reg  <= 1'b0;
            freeze_val_reg <= FREEZE_VAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEARN_RATE: learn_rate_reg <= cfg_data[23:0];
                CFG_REG_WEIGHT: reg_weight_reg <= cfg_data[15:0];
                CFG_FREEZE_EN:  freeze_en_reg  <= cfg_data[0];
                CFG_FREEZE_VAL: freeze_val_reg <= cfg_data[FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input capture ----------------
    logic                 s_acc;
    logic [FUNC_W-1:0]    func_reg;
    logic [FACTOR_W-1:0]  fin_reg;
    logic [RATING_W-1:0]  rating_reg;

    assign s_acc = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            func_reg   <= s_tuser;
            fin_reg    <= s_tdata[46:23];
            rating_reg <= s_tdata[54:47];
        end
    end

    // ---------------- index wrapping: three remainder lanes ----------------
    logic [ROW_W-1:0]  urem, irem;
    logic [FEAT_W-1:0] frem;

    sgdmf_rem #(.IN_W(ROW_W), .MOD(NUM_USERS)) u_rem_user (
        .clk(clk), .start(s_acc), .value(s_tdata[9:0]), .rem(urem)
    );

    sgdmf_rem #(.IN_W(ROW_W), .MOD(NUM_ITEMS)) u_rem_item (
        .clk(clk), .start(s_acc), .value(s_tdata[19:10]), .rem(irem)
    );

    sgdmf_rem #(.IN_W(FEAT_W), .MOD(FEATURES)) u_rem_feat (
        .clk(clk), .start(s_acc), .value(s_tdata[22:20]), .rem(frem)
    );

    // ---------------- sequencer state ----------------
    state_t state_reg, state_next;

    logic [UA_W-1:0]   ubase_reg;
    logic [IA_W-1:0]   ibase_reg;
    logic [FEAT_W-1:0] fidx_reg;
    logic [K_W-1:0]    k_reg;
    logic              k_last;
    logic              phase_reg;

    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [WORD_W-1:0]   pred_reg;
    logic signed [WORD_W-1:0]   err_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [FACTOR_W-1:0]        fout_reg;
    logic                       upd_reg;
    logic signed [FACTOR_W-1:0] p_reg, q_reg, np_reg;
    logic signed [56:0]         t1_reg;
    logic signed [56:0]         inner_reg;
    logic [24:0]                chi_reg;
    logic signed [41:0]         stepv_reg;

    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    assign k_last = (k_reg == K_W'(FEATURES - 1));

    // ---------------- factor tables ----------------
    logic                u_we, i_we;
    logic [UA_W-1:0]     u_addr_k, u_addr_f, u_raddr, u_waddr;
    logic [IA_W-1:0]     i_addr_k, i_addr_f, i_raddr, i_waddr;
    logic [FACTOR_W-1:0] u_wdata, i_wdata, u_rdata, i_rdata;

    assign u_addr_k = ubase_reg + UA_W'(k_reg);
    assign u_addr_f = ubase_reg + UA_W'(fidx_reg);
    assign i_addr_k = ibase_reg + IA_W'(k_reg);
    assign i_addr_f = ibase_reg + IA_W'(fidx_reg);

    always_comb
    begin
        u_raddr = (state_reg == S_RD) ? u_addr_f : u_addr_k;
        i_raddr = (state_reg == S_RD) ? i_addr_f : i_addr_k;
        u_waddr = (state_reg == S_WR) ? u_addr_f : u_addr_k;
        i_waddr = (state_reg == S_WR) ? i_addr_f : i_addr_k;
        u_wdata = (state_reg == S_WR) ? fin_reg : np_reg;
        i_wdata = (state_reg == S_WR) ? fin_reg : q_reg;
        u_we    = (state_reg == S_T_WR) ||
                  (state_reg == S_WR && func_reg == FUNC_WR_USER);
        i_we    = (state_reg == S_T_WR) ||
                  (state_reg == S_WR && func_reg == FUNC_WR_ITEM);
    end

    sgdmf_ram #(.DEPTH(UDEPTH), .AW(UA_W), .DW(FACTOR_W)) u_user_tab (
        .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
        .raddr(u_raddr), .rdata(u_rdata)
    );

    sgdmf_ram #(.DEPTH(IDEPTH), .AW(IA_W), .DW(FACTOR_W)) u_item_tab (
        .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
        .raddr(i_raddr), .rdata(i_rdata)
    );

    // ---------------- shared multiplier ----------------
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [FACTOR_W-1:0] self_v, other_v;

    // Step operands: the user step pairs p with q, the item step pairs q with new p.
    assign self_v  = phase_reg ? q_reg  : p_reg;
    assign other_v = phase_reg ? np_reg : q_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DOT_MUL:
            begin
                mul_a = MUL_W'($signed(u_rdata));
                mul_b = MUL_W'($signed(i_rdata));
            end
            S_SQ_MUL:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(err_reg);
            end
            S_ST_EO:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(other_v);
            end
            S_ST_RW:
            begin
                mul_a = $signed({17'b0, reg_weight_reg});
                mul_b = MUL_W'(self_v);
            end
            S_ST_LO:
            begin
                mul_a = $signed({9'b0, learn_rate_reg});
                mul_b = $signed({9'b0, inner_reg[23:0]});
            end
            S_ST_HI:
            begin
                mul_a = $signed({9'b0, learn_rate_reg});
                mul_b = inner_reg[56:24];
            end
            default: ;
        endcase
    end

    sgdmf_mul u_mul (
        .clk(clk), .a(mul_a), .b(mul_b), .prod_reg(prod_reg)
    );

    // ---------------- datapath helpers ----------------
    logic signed [ACC_W:0]    pred_rnd;
    logic signed [ACC_W:0]    pred_sh;
    logic signed [WORD_W-1:0] pred_sat;
    logic signed [33:0]       err_diff;
    logic signed [WORD_W-1:0] err_sat;
    logic [63:0]              sq_rnd;
    logic [48:0]              lo_rnd;
    logic signed [57:0]       step_sum;
    logic signed [42:0]       new_sum;
    logic signed [FACTOR_W-1:0] new_sat;
    logic                     frozen;

    always_comb
    begin
        // prediction: round half up from Q16.32, saturate to 32 bits
        pred_rnd = $signed({acc_reg[ACC_W-1], acc_reg}) + (ACC_W+1)'(32768);
        pred_sh  = pred_rnd >>> 16;
        if (pred_sh[ACC_W:31] == '0 || pred_sh[ACC_W:31] == '1)
        begin
            pred_sat = pred_sh[31:0];
        end
        else
        begin
            pred_sat = pred_sh[ACC_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end

        err_diff = $signed({10'b0, rating_reg, 16'b0}) - 34'(pred_reg);
        if (err_diff[33:31] == 3'b000 || err_diff[33:31] == 3'b111)
        begin
            err_sat = err_diff[31:0];
        end
        else
        begin
            err_sat = err_diff[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end

        // error squared never exceeds 2^62, so the Q32.16 result always fits
        sq_rnd = prod_reg[63:0] + 64'd32768;

        // low half of alpha*inner, rounding bias folded in
        lo_rnd   = {1'b0, prod_reg[47:0]} + 49'h80_0000_0000;
        step_sum = prod_reg[57:0] + $signed({33'b0, chi_reg});

        new_sum = 43'(self_v) + 43'(stepv_reg);
        if (new_sum[42:23] == '0 || new_sum[42:23] == '1)
        begin
            new_sat = new_sum[23:0];
        end
        else
        begin
            new_sat = new_sum[42] ? 24'sh80_0000 : 24'sh7F_FFFF;
        end

        frozen = freeze_en_reg && (u_rdata == freeze_val_reg);
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_acc) state_next = S_BASE;
            S_BASE:
            begin
                case (func_reg)
                    FUNC_WR_USER, FUNC_WR_ITEM: state_next = S_WR;
                    FUNC_RD_USER, FUNC_RD_ITEM: state_next = S_RD;
                    FUNC_TRAIN, FUNC_EVAL:      state_next = S_DOT_RD;
                    default:                    state_next = S_DONE;
                endcase
            end
            S_WR:      state_next = S_DONE;
            S_RD:      state_next = S_RD_DATA;
            S_RD_DATA: state_next = S_DONE;
            S_DOT_RD:  state_next = S_DOT_MUL;
            S_DOT_MUL: state_next = S_DOT_ACC;
            S_DOT_ACC: state_next = k_last ? S_PRED : S_DOT_RD;
            S_PRED:    state_next = (rating_reg == '0) ? S_DONE : S_ERR;
            S_ERR:     state_next = S_SQ_MUL;
            S_SQ_MUL:  state_next = S_SQ;
            S_SQ:      state_next = (func_reg == FUNC_TRAIN) ? S_T_RD : S_DONE;
            S_T_RD:    state_next = S_T_LD;
            S_T_LD:
            begin
                if (frozen)
                begin
                    state_next = k_last ? S_DONE : S_T_RD;
                end
                else
                begin
                    state_next = S_ST_EO;
                end
            end
            S_ST_EO:   state_next = S_ST_RW;
            S_ST_RW:   state_next = S_ST_IN;
            S_ST_IN:   state_next = S_ST_LO;
            S_ST_LO:   state_next = S_ST_HI;
            S_ST_HI:   state_next = S_ST_SUM;
            S_ST_SUM:  state_next = S_ST_NEW;
            S_ST_NEW:  state_next = phase_reg ? S_T_WR : S_ST_EO;
            S_T_WR:    state_next = k_last ? S_DONE : S_T_RD;
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                // clear the fields a function leaves untouched
                pred_reg <= '0;
                err_reg  <= '0;
                sq_reg   <= '0;
                fout_reg <= '0;
                upd_reg  <= 1'b0;
            end
            S_BASE:
            begin
                ubase_reg <= UA_W'(urem * FEATURES);
                ibase_reg <= IA_W'(irem * FEATURES);
                fidx_reg  <= frem;
                k_reg     <= '0;
                acc_reg   <= '0;
            end
            S_WR:      fout_reg <= fin_reg;
            S_RD_DATA: fout_reg <= (func_reg == FUNC_RD_USER) ? u_rdata : i_rdata;
            S_DOT_ACC:
            begin
                acc_reg <= acc_reg + ACC_W'($signed(prod_reg[47:0]));
                k_reg   <= k_last ? '0 : k_reg + 1'b1;
            end
            S_PRED:    pred_reg <= pred_sat;
            S_ERR:     err_reg  <= err_sat;
            S_SQ:      sq_reg   <= sq_rnd[63:16];
            S_T_LD:
            begin
                p_reg     <= u_rdata;
                q_reg     <= i_rdata;
                phase_reg <= 1'b0;
                if (frozen)
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            S_ST_RW:   t1_reg    <= {prod_reg[55:0], 1'b0};
            S_ST_IN:   inner_reg <= t1_reg - 57'($signed(prod_reg[40:0]));
            S_ST_HI:   chi_reg   <= lo_rnd[48:24];
            S_ST_SUM:  stepv_reg <= step_sum[57:16];
            S_ST_NEW:
            begin
                if (phase_reg)
                begin
                    // q_reg takes the new item factor here; the change test below
                    // compares the new p and q against the old p and q
                    if (np_reg != p_reg || new_sat != q_reg)
                    begin
                        upd_reg <= 1'b1;
                    end
                    q_reg <= new_sat;
                end
                else
                begin
                    np_reg    <= new_sat;
                    phase_reg <= 1'b1;
                end
            end
            S_T_WR:    k_reg <= k_reg + 1'b1;
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= {7'b0, upd_reg, fout_reg, sq_reg, err_reg, pred_reg};
        end
    end

    // accept only when idle; a waiting result does not block accepting the next item
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/sgdmf_checker.sv -----
// ----------------------------------------------------------------------------
// sgdmf_checker: port-level checks for the SGD factorization engine
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module sgdmf_checker
    import sgdmf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // zero error gives zero squared error
    a_sq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[63:32] == 32'd0 |-> m_tdata[111:64] == 48'd0)
        else $error("squared error without error");

    // an update comes only from training, which reports no factor
    a_upd_no_factor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[136] |-> m_tdata[135:112] == 24'd0
            && m_tdata[143:137] == 7'd0)
        else $error("update flag on a factor transaction");

endmodule

bind sgd_matrix_factorization_update_top sgdmf_checker u_sgdmf_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
